// ===== rtl/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// tds_pkg: shared types and arithmetic for the tridiagonal solver
// Holds the value and item types, the divider handshake structs and the
// fixed-point saturate and product-scaling helpers.
// ----------------------------------------------------------------------------
package tds_pkg;

    localparam int VALUE_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int MAX_ROWS  = 64;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int DIV_LANES = 3;
    localparam int FIFO_DEPTH = 2;

    typedef logic signed [VALUE_W-1:0] value_t;

    localparam value_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam value_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // One row as the front classifies it.
    typedef struct packed {
        value_t           sub_diag;
        value_t           main_diag;
        value_t           super_diag;
        value_t           rhs_value;
        logic [ROW_W-1:0] row;
        logic             first;
        logic             last;
    } row_item_t;

    // One result as the back part emits it.
    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        value_t           solution;
        value_t           diag_factor;
        value_t           lower_factor;
        value_t           upper_factor;
        logic             singular;
        logic             result_last;
    } result_t;

    typedef struct packed {
        logic                       start;
        value_t                     divisor;
        value_t [DIV_LANES-1:0]     num;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic                       zero;
        value_t [DIV_LANES-1:0]     quot;
    } div_rsp_t;

    function automatic value_t sat_val(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'(VAL_MAX);
        lo = 64'(VAL_MIN);
        if (v > hi) begin
            return VAL_MAX;
        end else if (v < lo) begin
            return VAL_MIN;
        end
        return v[VALUE_W-1:0];
    endfunction

    // Scales a full product back to Q format, truncating toward zero.
    function automatic value_t fx_scale(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p[63] ? p + ((64'sd1 <<< FRAC_W) - 64'sd1) : p;
        return sat_val(adj >>> FRAC_W);
    endfunction

endpackage

// ===== rtl/tds_fifo.sv =====
// ----------------------------------------------------------------------------
// tds_fifo: two-entry row queue
// Decouples the front classifier from the solver back end.
// ----------------------------------------------------------------------------
module tds_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tds_pkg::row_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output tds_pkg::row_item_t  head_item
);

    localparam int PTR_W = $clog2(tds_pkg::FIFO_DEPTH);

    tds_pkg::row_item_t entry_reg [tds_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full      = (count_reg == (PTR_W+1)'(tds_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/tds_front.sv =====
// ----------------------------------------------------------------------------
// tds_front: input side of the solver
// Accepts row beats, numbers them and marks the first and last row of a run.
// ----------------------------------------------------------------------------
module tds_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tds_pkg::value_t     sub_diag,
    input  tds_pkg::value_t     main_diag,
    input  tds_pkg::value_t     super_diag,
    input  tds_pkg::value_t     rhs_value,
    input  logic                row_last,
    output logic                push,
    output tds_pkg::row_item_t  push_item,
    input  logic                queue_full
);

    logic [tds_pkg::ROW_W-1:0] row_cnt_reg;
    logic                      force_last;

    assign s_tready   = !queue_full;
    assign push       = s_tvalid && !queue_full;
    // A run that reaches the last storage row ends there.
    assign force_last = (row_cnt_reg == tds_pkg::ROW_W'(tds_pkg::MAX_ROWS - 1));

    always_comb begin
        push_item.sub_diag   = sub_diag;
        push_item.main_diag  = main_diag;
        push_item.super_diag = super_diag;
        push_item.rhs_value  = rhs_value;
        push_item.row        = row_cnt_reg;
        push_item.first      = (row_cnt_reg == '0);
        push_item.last       = row_last || force_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
        end else if (push) begin
            row_cnt_reg <= push_item.last ? '0 : row_cnt_reg + 1'b1;
        end
    end

endmodule

// ===== rtl/tds_div.sv =====
// ----------------------------------------------------------------------------
// tds_div: three-lane radix-2 fixed-point divider
// All lanes share one divisor and retire one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tds_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  tds_pkg::div_req_t req,
    output tds_pkg::div_rsp_t rsp
);

    localparam int W     = tds_pkg::VALUE_W;
    localparam int SH    = tds_pkg::VALUE_W - tds_pkg::FRAC_W;
    localparam int CNT_W = $clog2(W + 1);
    localparam int L     = tds_pkg::DIV_LANES;

    logic [W:0]       dmag_reg;
    logic             zero_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W:0]       rem_reg [L];
    logic [W-1:0]     low_reg [L];
    logic [W-1:0]     q_reg   [L];
    logic             ovf_reg [L];
    logic             neg_reg [L];
    tds_pkg::div_rsp_t rsp_reg;

    logic [W:0]       trial   [L];
    logic             ge      [L];
    logic [W:0]       nmag    [L];
    logic             ovf_in  [L];
    logic [W:0]       dmag_in;
    tds_pkg::value_t  fin     [L];

    assign rsp = rsp_reg;

    always_comb begin
        logic signed [W:0] dext;
        dext    = {req.divisor[W-1], req.divisor};
        dmag_in = dext[W] ? (W+1)'(-dext) : dext;
        for (int l = 0; l < L; l++) begin
            nmag[l]   = req.num[l][W-1] ? (W+1)'(-{req.num[l][W-1], req.num[l]})
                                        : {1'b0, req.num[l]};
            ovf_in[l] = ({{(W-SH){1'b0}}, nmag[l]} >= {dmag_in, {SH{1'b0}}});
            trial[l]  = {rem_reg[l][W-1:0], low_reg[l][W-1]};
            ge[l]     = (trial[l] >= dmag_reg);
            if (zero_reg) begin
                fin[l] = '0;
            end else if (ovf_reg[l]) begin
                fin[l] = neg_reg[l] ? tds_pkg::VAL_MIN : tds_pkg::VAL_MAX;
            end else if (neg_reg[l]) begin
                fin[l] = (q_reg[l] > tds_pkg::VAL_MIN) ? tds_pkg::VAL_MIN : -q_reg[l];
            end else begin
                fin[l] = q_reg[l][W-1] ? tds_pkg::VAL_MAX : q_reg[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dmag_reg <= dmag_in;
            zero_reg <= (req.divisor == '0);
        end
        for (int l = 0; l < L; l++) begin
            if (req.start) begin
                rem_reg[l] <= (W+1)'(nmag[l] >> SH);
                low_reg[l] <= {nmag[l][SH-1:0], {(W-SH){1'b0}}};
                q_reg[l]   <= '0;
                ovf_reg[l] <= ovf_in[l];
                neg_reg[l] <= req.num[l][W-1] ^ req.divisor[W-1];
            end else if (busy_reg && cnt_reg != '0) begin
                rem_reg[l] <= ge[l] ? trial[l] - dmag_reg : trial[l];
                low_reg[l] <= {low_reg[l][W-2:0], 1'b0};
                q_reg[l]   <= {q_reg[l][W-2:0], ge[l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            rsp_reg.done <= 1'b0;
        end else begin
            rsp_reg.done <= busy_reg && cnt_reg == '0;
            if (busy_reg && cnt_reg == '0) begin
                for (int l = 0; l < L; l++) begin
                    rsp_reg.quot[l] <= fin[l];
                end
                rsp_reg.zero <= zero_reg;
            end
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/tds_back.sv =====
// ----------------------------------------------------------------------------
// tds_back: factorization and substitution sequencer
// Pops rows from the queue, runs the LDU step per row, and on the last row
// finishes the solve and emits results from the highest row down.
// ----------------------------------------------------------------------------
module tds_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  tds_pkg::row_item_t  item,
    output logic                item_pop,
    output tds_pkg::div_req_t   div_req,
    input  tds_pkg::div_rsp_t   div_rsp,
    output logic                res_valid,
    input  logic                res_ready,
    output tds_pkg::result_t    res
);

    localparam int RW = tds_pkg::ROW_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_DIV, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_UPDATE,
        ST_ZDIV, ST_READ, ST_BMUL, ST_BSUB
    } state_t;

    state_t             state_reg;
    tds_pkg::row_item_t cur_reg;
    tds_pkg::value_t    pivot_prev_reg, y_prev_reg, held_sup_reg;
    tds_pkg::value_t    lf_reg, uf_reg, t1_reg, ym_reg, xnext_reg;
    logic               singular_reg;
    logic [RW-1:0]      idx_reg;
    logic signed [63:0] prod_reg;
    logic               res_valid_reg;
    tds_pkg::result_t   res_reg;

    tds_pkg::value_t pivot_mem [tds_pkg::MAX_ROWS];
    tds_pkg::value_t lower_mem [tds_pkg::MAX_ROWS];
    tds_pkg::value_t upper_mem [tds_pkg::MAX_ROWS];
    tds_pkg::value_t z_mem     [tds_pkg::MAX_ROWS];
    tds_pkg::value_t pivot_rd_reg, lower_rd_reg, upper_rd_reg, z_rd_reg;

    logic            piv_we, low_we, up_we, z_we;
    logic [RW-1:0]   piv_wa, low_wa, up_wa, z_wa;
    tds_pkg::value_t piv_wd, low_wd, up_wd, z_wd;

    tds_pkg::value_t mul_a, mul_b, scaled, pivot_new, y_new, x_new;
    logic [RW-1:0]   row_prev;
    logic            emit;

    assign item_pop  = (state_reg == ST_IDLE) && item_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign row_prev  = cur_reg.row - 1'b1;
    assign scaled    = tds_pkg::fx_scale(prod_reg);
    assign pivot_new = tds_pkg::sat_val(64'(cur_reg.main_diag) - 64'(scaled));
    assign y_new     = tds_pkg::sat_val(64'(cur_reg.rhs_value) - 64'(ym_reg));
    assign x_new     = tds_pkg::sat_val(64'(z_rd_reg) - 64'(scaled));
    assign emit      = (state_reg == ST_BSUB) && (!res_valid_reg || res_ready);

    always_comb begin
        case (state_reg)
            ST_MUL_A: begin mul_a = lf_reg;     mul_b = pivot_prev_reg; end
            ST_MUL_B: begin mul_a = y_prev_reg; mul_b = lf_reg;         end
            ST_MUL_C: begin mul_a = t1_reg;     mul_b = uf_reg;         end
            default:  begin mul_a = upper_rd_reg; mul_b = xnext_reg;    end
        endcase
    end

    always_comb begin
        div_req.start   = 1'b0;
        div_req.divisor = pivot_prev_reg;
        div_req.num[0]  = cur_reg.sub_diag;
        div_req.num[1]  = held_sup_reg;
        div_req.num[2]  = y_prev_reg;
        if (state_reg == ST_LOAD) begin
            div_req.start = 1'b1;
            if (cur_reg.first) begin
                div_req.start   = cur_reg.last;
                div_req.divisor = cur_reg.main_diag;
                div_req.num[0]  = cur_reg.rhs_value;
            end
        end else if (state_reg == ST_UPDATE) begin
            div_req.start   = cur_reg.last;
            div_req.divisor = pivot_new;
            div_req.num[0]  = y_new;
        end
    end

    // Store write ports.
    always_comb begin
        piv_we = 1'b0; piv_wa = cur_reg.row; piv_wd = cur_reg.main_diag;
        low_we = 1'b0; low_wa = cur_reg.row; low_wd = '0;
        up_we  = 1'b0; up_wa  = row_prev;    up_wd  = div_rsp.quot[1];
        z_we   = 1'b0; z_wa   = row_prev;    z_wd   = div_rsp.quot[2];
        case (state_reg)
            ST_LOAD: begin
                piv_we = cur_reg.first;
                low_we = cur_reg.first;
                // A single-row run has no upper link.
                up_we  = cur_reg.first && cur_reg.last;
                up_wa  = cur_reg.row;
                up_wd  = '0;
            end
            ST_DIV: begin
                low_we = div_rsp.done;
                low_wd = div_rsp.quot[0];
                up_we  = div_rsp.done;
                z_we   = div_rsp.done;
            end
            ST_UPDATE: begin
                piv_we = 1'b1;
                piv_wd = pivot_new;
                up_we  = cur_reg.last;
                up_wa  = cur_reg.row;
                up_wd  = '0;
            end
            ST_ZDIV: begin
                z_we = div_rsp.done;
                z_wa = cur_reg.row;
                z_wd = div_rsp.quot[0];
            end
            default: begin
                piv_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (piv_we) pivot_mem[piv_wa] <= piv_wd;
        if (low_we) lower_mem[low_wa] <= low_wd;
        if (up_we)  upper_mem[up_wa]  <= up_wd;
        if (z_we)   z_mem[z_wa]       <= z_wd;
        pivot_rd_reg <= pivot_mem[idx_reg];
        lower_rd_reg <= lower_mem[idx_reg];
        upper_rd_reg <= upper_mem[idx_reg];
        z_rd_reg     <= z_mem[idx_reg];
        prod_reg     <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            singular_reg  <= 1'b0;
            held_sup_reg  <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (item_valid) begin
                        cur_reg   <= item;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (cur_reg.first) begin
                        pivot_prev_reg <= cur_reg.main_diag;
                        y_prev_reg     <= cur_reg.rhs_value;
                        held_sup_reg   <= cur_reg.super_diag;
                        state_reg      <= cur_reg.last ? ST_ZDIV : ST_IDLE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        lf_reg       <= div_rsp.quot[0];
                        uf_reg       <= div_rsp.quot[1];
                        singular_reg <= singular_reg | div_rsp.zero;
                        state_reg    <= ST_MUL_A;
                    end
                end
                ST_MUL_A: state_reg <= ST_MUL_B;
                ST_MUL_B: begin
                    t1_reg    <= scaled;
                    state_reg <= ST_MUL_C;
                end
                ST_MUL_C: begin
                    ym_reg    <= scaled;
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    pivot_prev_reg <= pivot_new;
                    y_prev_reg     <= y_new;
                    held_sup_reg   <= cur_reg.super_diag;
                    state_reg      <= cur_reg.last ? ST_ZDIV : ST_IDLE;
                end
                ST_ZDIV: begin
                    if (div_rsp.done) begin
                        singular_reg <= singular_reg | div_rsp.zero;
                        idx_reg      <= cur_reg.row;
                        xnext_reg    <= '0;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_BMUL;
                ST_BMUL: state_reg <= ST_BSUB;
                ST_BSUB: begin
                    if (emit) begin
                        res_reg.row_index    <= idx_reg;
                        res_reg.solution     <= x_new;
                        res_reg.diag_factor  <= pivot_rd_reg;
                        res_reg.lower_factor <= lower_rd_reg;
                        res_reg.upper_factor <= upper_rd_reg;
                        res_reg.singular     <= singular_reg;
                        res_reg.result_last  <= (idx_reg == '0);
                        xnext_reg            <= x_new;
                        if (idx_reg == '0) begin
                            singular_reg <= 1'b0;
                            held_sup_reg <= '0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV || state_reg == ST_ZDIV))
        else $error("divider finished while no division was pending");

    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && idx_reg == '0) |=> (res_valid_reg && res_reg.result_last
                                     && state_reg == ST_IDLE))
        else $error("row zero result did not close the run");

    a_div_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |=> !div_rsp.done)
        else $error("divider answered in one cycle");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop |=> (state_reg == ST_LOAD))
        else $error("popped row was not loaded");

endmodule

// ===== rtl/tridiagonal_ldu_solver.sv =====
// ----------------------------------------------------------------------------
// tridiagonal_ldu_solver: streaming tridiagonal system solver (LDU / Thomas)
// Rows of a signed Q16.16 tridiagonal system come in; solutions and factors
// come out, one beat per row, from the highest row down to row zero.
// ----------------------------------------------------------------------------
// Usage: send one beat per matrix row on the s_ channel, row zero first, and
// raise s_tlast on the final row. A run holds at most 64 rows; the 64th row
// ends the run even without s_tlast. Rows that are not last give no output.
// Each row after the first takes, in the back end, one shared divider pass
// (L, U and the previous quotient at once) and three multiplies on one
// 32x32 multiplier. The last row adds a second division, then results leave
// one beat at a time, each one waiting on one multiply and one subtract of
// back substitution.
// A two-beat queue lets the input accept rows while the back end works.
// When the receiver stalls m_tready, the result beat holds and the back end
// waits; the queue then fills and s_tready falls.
// Reset (aresetn low, synchronous) empties the queue and drops any partial
// run; the row stores need no clearing.
// ----------------------------------------------------------------------------
module tridiagonal_ldu_solver (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata, from bit 0: sub_diag, main_diag, super_diag, rhs_value
    input  logic [127:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tlast,
    // m_tdata, from bit 0: row_index, solution, diag_factor, lower_factor,
    // upper_factor, two zero pad bits
    output logic [135:0] m_tdata,
    // m_tuser, from bit 0: singular
    output logic [0:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tlast
);

    localparam int W = tds_pkg::VALUE_W;

    logic               push, queue_full, pop, not_empty;
    tds_pkg::row_item_t push_item, head_item;
    tds_pkg::div_req_t  div_req;
    tds_pkg::div_rsp_t  div_rsp;
    tds_pkg::result_t   res;

    // Front: numbering and classification of rows.
    tds_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .sub_diag   (s_tdata[W-1:0]),
        .main_diag  (s_tdata[2*W-1:W]),
        .super_diag (s_tdata[3*W-1:2*W]),
        .rhs_value  (s_tdata[4*W-1:3*W]),
        .row_last   (s_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    tds_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_item (head_item)
    );

    // Back: factorization, substitution and the result register.
    tds_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (not_empty),
        .item       (head_item),
        .item_pop   (pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    tds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tdata = {2'b00, res.upper_factor, res.lower_factor, res.diag_factor,
                      res.solution, res.row_index};
    assign m_tuser = res.singular;
    assign m_tlast = res.result_last;

endmodule

// ===== test/tb_tridiagonal_ldu_solver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tridiagonal_ldu_solver: self-checking bench for the tridiagonal solver
// Streams tridiagonal systems into the solver. A behavioral LDU solver in
// the bench predicts every result beat, and each beat is compared field by
// field. Directed systems come first, then random systems of random sizes.
// ----------------------------------------------------------------------------
module tb_tridiagonal_ldu_solver;

    localparam int CLK_HALF = 4;
    localparam int ITEMS    = 150;

    // One row of a system as it goes onto the s_ channel.
    typedef struct {
        logic [31:0] sub_diag;
        logic [31:0] main_diag;
        logic [31:0] super_diag;
        logic [31:0] rhs_value;
        logic        row_last;
    } row_beat_t;

    // One expected result beat.
    typedef struct {
        logic [5:0]  row_index;
        logic [31:0] solution;
        logic [31:0] diag_factor;
        logic [31:0] lower_factor;
        logic [31:0] upper_factor;
        logic        singular;
        logic        result_last;
    } solved_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [127:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic         s_tlast = 1'b0;
    logic [135:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         m_tlast;

    solved_row_t pending_solutions[$];
    int          fail_count = 0;

    // Bench copy of the solver state.
    logic signed [31:0] piv_mem[64];
    logic signed [31:0] low_mem[64];
    logic signed [31:0] upp_mem[64];
    logic signed [31:0] fwd_mem[64];
    int                 loaded_rows = 0;
    logic signed [31:0] carried_super = '0;
    bit                 pivot_was_zero = 1'b0;

    tridiagonal_ldu_solver u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Q16.16 product, truncated toward zero.
    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return clamp32(p / 64'sd65536);
    endfunction

    // Q16.16 quotient; a zero divisor yields zero and marks the run singular.
    function automatic logic signed [31:0] q_div(input logic signed [31:0] a,
                                                 input logic signed [31:0] d);
        logic signed [63:0] num;
        if (d == 0) begin
            pivot_was_zero = 1'b1;
            return '0;
        end
        num = 64'(a) * 64'sd65536;
        return clamp32(num / 64'(d));
    endfunction

    // Folds one row into the factorization; on the last row, solves and
    // queues the result beats from the top row down.
    task automatic factor_row(input row_beat_t rb);
        int                 r;
        int                 k;
        logic signed [31:0] lf;
        logic signed [31:0] uf;
        logic signed [31:0] t;
        logic signed [31:0] xnext;
        logic signed [31:0] quot[64];
        solved_row_t        sr;
        r = (loaded_rows >= tds_pkg::MAX_ROWS) ? tds_pkg::MAX_ROWS - 1 : loaded_rows;
        if (r == 0) begin
            piv_mem[0] = rb.main_diag;
            low_mem[0] = '0;
            fwd_mem[0] = rb.rhs_value;
        end else begin
            lf = q_div(rb.sub_diag, piv_mem[r-1]);
            uf = q_div(carried_super, piv_mem[r-1]);
            t  = q_mul(q_mul(lf, piv_mem[r-1]), uf);
            upp_mem[r-1] = uf;
            low_mem[r]   = lf;
            piv_mem[r]   = clamp32(64'(signed'(rb.main_diag)) - 64'(t));
            fwd_mem[r]   = clamp32(64'(signed'(rb.rhs_value))
                                   - 64'(q_mul(fwd_mem[r-1], lf)));
        end
        carried_super = rb.super_diag;
        if (!rb.row_last && r < tds_pkg::MAX_ROWS - 1) begin
            loaded_rows = r + 1;
            return;
        end
        upp_mem[r] = '0;
        for (k = 0; k <= r; k++) begin
            quot[k] = q_div(fwd_mem[k], piv_mem[k]);
        end
        xnext = '0;
        for (k = r; k >= 0; k--) begin
            sr.row_index    = 6'(k);
            sr.solution     = clamp32(64'(quot[k]) - 64'(q_mul(upp_mem[k], xnext)));
            sr.diag_factor  = piv_mem[k];
            sr.lower_factor = low_mem[k];
            sr.upper_factor = upp_mem[k];
            sr.singular     = pivot_was_zero;
            sr.result_last  = (k == 0);
            pending_solutions.push_back(sr);
            xnext = sr.solution;
        end
        loaded_rows    = 0;
        carried_super  = '0;
        pivot_was_zero = 1'b0;
    endtask

    // Sends one row beat after a random gap; the prediction runs on accept.
    // The beat stays valid until the next gap or an explicit idle.
    task automatic send_row(input row_beat_t rb);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) begin
            gap = 0;
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) begin
                @(negedge aclk);
            end
        end
        s_tdata  <= {rb.rhs_value, rb.super_diag, rb.main_diag, rb.sub_diag};
        s_tlast  <= rb.row_last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        factor_row(rb);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    // Random system; mostly diagonally dominant so the solve stays well posed.
    task automatic send_random_system(input int rows);
        row_beat_t rb;
        int        k;
        bit        dominant;
        dominant = ($urandom_range(0, 3) != 0);
        for (k = 0; k < rows; k++) begin
            rb.sub_diag   = random_value();
            rb.super_diag = random_value();
            rb.rhs_value  = random_value();
            rb.main_diag  = random_value();
            if (dominant) begin
                rb.sub_diag   = 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
                rb.super_diag = 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
                rb.main_diag  = 32'($urandom_range(3 << 16, 40 << 16));
                if ($urandom_range(0, 1)) begin
                    rb.main_diag = -rb.main_diag;
                end
            end
            rb.row_last = (k == rows - 1);
            send_row(rb);
        end
    endtask

    // Result side: random stalls, field checks against the oldest expectation.
    initial begin
        solved_row_t exp_sr;
        int          stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = $urandom_range(0, 11);
            if ($urandom_range(0, 2) == 0) begin
                stall = 0;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) begin
                    @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) begin
                @(posedge aclk);
            end
            if (pending_solutions.size() == 0) begin
                $error("unexpected result beat, row_index %0d", m_tdata[5:0]);
                fail_count++;
            end else begin
                exp_sr = pending_solutions.pop_front();
                if (m_tdata[5:0] !== exp_sr.row_index) begin
                    $error("row_index exp %0d got %0d", exp_sr.row_index, m_tdata[5:0]);
                    fail_count++;
                end
                if (m_tdata[37:6] !== exp_sr.solution) begin
                    $error("solution exp %h got %h", exp_sr.solution, m_tdata[37:6]);
                    fail_count++;
                end
                if (m_tdata[69:38] !== exp_sr.diag_factor) begin
                    $error("diag_factor exp %h got %h", exp_sr.diag_factor,
                           m_tdata[69:38]);
                    fail_count++;
                end
                if (m_tdata[101:70] !== exp_sr.lower_factor) begin
                    $error("lower_factor exp %h got %h", exp_sr.lower_factor,
                           m_tdata[101:70]);
                    fail_count++;
                end
                if (m_tdata[133:102] !== exp_sr.upper_factor) begin
                    $error("upper_factor exp %h got %h", exp_sr.upper_factor,
                           m_tdata[133:102]);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_sr.singular) begin
                    $error("singular exp %b got %b", exp_sr.singular, m_tuser[0]);
                    fail_count++;
                end
                if (m_tlast !== exp_sr.result_last) begin
                    $error("result_last exp %b got %b", exp_sr.result_last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus. The directed table covers extremes, zero pivots, single-row
    // systems and a plain 2x2 system; every row goes through the predictor.
    initial begin
        row_beat_t directed_rows[$];
        row_beat_t rb;
        int        k;
        int        sent;
        aresetn = 1'b0;
        repeat (6) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        aresetn = 1'b1;

        // Single-row system: x = b / D.
        directed_rows.push_back('{32'h7FFF_FFFF, 32'h0002_0000, 32'h8000_0000,
                                  32'h0006_0000, 1'b1});
        // Single-row system with a zero pivot: singular, zero solution.
        directed_rows.push_back('{32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b1});
        // 2x2 identity-like system.
        directed_rows.push_back('{32'h1234_5678, 32'h0001_0000, 32'h0, 32'h0003_0000, 1'b0});
        directed_rows.push_back('{32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFD_0000, 1'b1});
        // Extremes that saturate every stage.
        directed_rows.push_back('{32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 1'b0});
        directed_rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 1'b0});
        directed_rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 1'b1});
        // Zero pivot at the start of a run.
        directed_rows.push_back('{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0});
        directed_rows.push_back('{32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                                  32'h0002_0000, 1'b0});
        directed_rows.push_back('{32'h0001_0000, 32'hFFFE_0000, 32'h0, 32'h5555_AAAA, 1'b1});
        // Run after a singular run must start clean.
        directed_rows.push_back('{32'hAAAA_5555, 32'h0004_0000, 32'h0001_0000,
                                  32'h0001_0000, 1'b0});
        directed_rows.push_back('{32'h0001_0000, 32'h0004_0000, 32'h5555_AAAA,
                                  32'hFFFF_0000, 1'b1});
        foreach (directed_rows[i]) begin
            send_row(directed_rows[i]);
        end
        sent = directed_rows.size();

        // Full-length run without tlast: row 63 ends it on its own.
        for (k = 0; k < tds_pkg::MAX_ROWS; k++) begin
            rb = '{32'h0000_8000, 32'h0004_0000, 32'hFFFF_8000, random_value(), 1'b0};
            send_row(rb);
        end
        sent += tds_pkg::MAX_ROWS;

        // Hold the sender until every queued result has drained.
        s_tvalid <= 1'b0;
        while (pending_solutions.size() != 0) begin
            @(negedge aclk);
        end

        while (sent < ITEMS) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                            : $urandom_range(1, 8);
            if (k > ITEMS - sent) begin
                k = ITEMS - sent;
            end
            send_random_system(k);
            sent += k;
        end

        s_tvalid <= 1'b0;
        while (pending_solutions.size() != 0) begin
            @(negedge aclk);
        end
        repeat (200) begin
            @(posedge aclk);
        end
        if (fail_count == 0) begin
            $display("[tridiagonal_ldu_solver] OK");
        end else begin
            $display("[tridiagonal_ldu_solver] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with maximal stalls.
    initial begin
        #(20_000_000);
        $display("[tridiagonal_ldu_solver] ERROR");
        $finish;
    end

endmodule
